// File: rtl/core/nearest_neighbor_image_rotate_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the image rotation core
// Shorthand for the concurrent checks in the core's top module.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_IMAGE_ROTATE_DEFINES_SVH
`define NEAREST_NEIGHBOR_IMAGE_ROTATE_DEFINES_SVH

// Checks a property on every clock edge while reset is not asserted.
`define NNIR_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("nnir assertion failed");

// Checks a property on every clock edge, reset included.
`define NNIR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("nnir assertion failed");

`endif

// File: rtl/core/nnir_pkg.sv
// ----------------------------------------------------------------------------
// Image rotation package
// Widths, codes and shared types of the nearest neighbor rotation core.
// ----------------------------------------------------------------------------
package nnir_pkg;

    localparam int MAX_SIDE   = 256;
    localparam int SIDE_BITS  = $clog2(MAX_SIDE);
    localparam int SIZE_W     = SIDE_BITS + 1;
    localparam int ADDR_W     = 2 * SIDE_BITS;
    localparam int PIXEL_W    = 32;
    localparam int TRIG_W     = 16;
    localparam int FRAC_BITS  = 14;
    localparam int DELTA_W    = SIDE_BITS + 2;
    localparam int PROD_W     = DELTA_W + TRIG_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int RND_W      = SUM_W - FRAC_BITS;
    localparam int POS_W      = RND_W + 1;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TRIG_W;

    localparam logic [PIXEL_W-1:0] WHITE_PIXEL  = '1;
    localparam logic [TRIG_W-1:0]  COS_RESET    = TRIG_W'(1 << FRAC_BITS);
    localparam logic [TRIG_W-1:0]  SIN_RESET    = '0;
    localparam logic [SIZE_W-1:0]  SIDE_RESET   = SIZE_W'(MAX_SIDE);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS    = 2'd0,
        REG_SIN    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_RND,
        ST_ADDR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic rnd;
    } map_ctl_t;

endpackage

// File: rtl/core/nnir_store.sv
// ----------------------------------------------------------------------------
// Frame store
// Single write port and single registered read port over the source frame.
// ----------------------------------------------------------------------------
module nnir_store (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [nnir_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [nnir_pkg::PIXEL_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [nnir_pkg::ADDR_W-1:0]  rd_addr,
    output logic [nnir_pkg::PIXEL_W-1:0] rd_data
);

    logic [nnir_pkg::PIXEL_W-1:0] mem [nnir_pkg::MAX_SIDE * nnir_pkg::MAX_SIDE];
    logic [nnir_pkg::PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/nnir_map.sv
// ----------------------------------------------------------------------------
// Coordinate mapper
// Maps an output pixel back into the source frame over four register stages.
// ----------------------------------------------------------------------------
module nnir_map (
    input  logic                                aclk,
    input  nnir_pkg::map_ctl_t                  ctl,
    input  logic [nnir_pkg::SIDE_BITS-1:0]      pos_x,
    input  logic [nnir_pkg::SIDE_BITS-1:0]      pos_y,
    input  logic signed [nnir_pkg::TRIG_W-1:0]  cos_q,
    input  logic signed [nnir_pkg::TRIG_W-1:0]  sin_q,
    input  logic [nnir_pkg::SIZE_W-1:0]         width_eff,
    input  logic [nnir_pkg::SIZE_W-1:0]         height_eff,
    output logic [nnir_pkg::ADDR_W-1:0]         src_addr,
    output logic                                src_hit
);

    localparam int SB = nnir_pkg::SIDE_BITS;

    logic [SB-1:0] cx;
    logic [SB-1:0] cy;

    logic signed [nnir_pkg::DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [nnir_pkg::DELTA_W-1:0] dx_next, dy_next;
    logic                                in_img_reg, in_img_next;

    logic signed [nnir_pkg::PROD_W-1:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic signed [nnir_pkg::SUM_W-1:0]  sum_x_reg, sum_y_reg;
    logic signed [nnir_pkg::SUM_W-1:0]  sum_x_next, sum_y_next;

    logic signed [nnir_pkg::SUM_W-1:0]  bias_x, bias_y;
    logic signed [nnir_pkg::SUM_W-1:0]  biased_x, biased_y;
    logic signed [nnir_pkg::SUM_W-1:0]  shifted_x, shifted_y;
    logic signed [nnir_pkg::RND_W-1:0]  rnd_x_reg, rnd_y_reg;
    logic signed [nnir_pkg::RND_W-1:0]  rnd_x_next, rnd_y_next;

    logic signed [nnir_pkg::POS_W-1:0]  src_x, src_y;
    logic signed [nnir_pkg::POS_W-1:0]  lim_x, lim_y;

    assign cx = width_eff[SB:1];
    assign cy = height_eff[SB:1];

    always_comb begin
        dx_next     = $signed({2'b00, pos_x}) - $signed({2'b00, cx});
        dy_next     = $signed({2'b00, pos_y}) - $signed({2'b00, cy});
        in_img_next = ({1'b0, pos_x} < width_eff) && ({1'b0, pos_y} < height_eff);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            in_img_reg <= in_img_next;
        end
        if (ctl.mul) begin
            p_xc_reg <= dx_reg * cos_q;
            p_ys_reg <= dy_reg * sin_q;
            p_xs_reg <= dx_reg * sin_q;
            p_yc_reg <= dy_reg * cos_q;
        end
        if (ctl.sum) begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
        if (ctl.rnd) begin
            rnd_x_reg <= rnd_x_next;
            rnd_y_reg <= rnd_y_next;
        end
    end

    always_comb begin
        sum_x_next = nnir_pkg::SUM_W'(p_xc_reg) + nnir_pkg::SUM_W'(p_ys_reg);
        sum_y_next = nnir_pkg::SUM_W'(p_yc_reg) - nnir_pkg::SUM_W'(p_xs_reg);
    end

    // Rounding half away from zero: a negative value takes one less of bias
    // before the arithmetic shift.
    always_comb begin
        bias_x     = sum_x_reg[nnir_pkg::SUM_W-1] ?
                     nnir_pkg::SUM_W'(nnir_pkg::ROUND_HALF - 1) :
                     nnir_pkg::SUM_W'(nnir_pkg::ROUND_HALF);
        bias_y     = sum_y_reg[nnir_pkg::SUM_W-1] ?
                     nnir_pkg::SUM_W'(nnir_pkg::ROUND_HALF - 1) :
                     nnir_pkg::SUM_W'(nnir_pkg::ROUND_HALF);
        biased_x   = sum_x_reg + bias_x;
        biased_y   = sum_y_reg + bias_y;
        shifted_x  = biased_x >>> nnir_pkg::FRAC_BITS;
        shifted_y  = biased_y >>> nnir_pkg::FRAC_BITS;
        rnd_x_next = shifted_x[nnir_pkg::RND_W-1:0];
        rnd_y_next = shifted_y[nnir_pkg::RND_W-1:0];
    end

    always_comb begin
        src_x    = nnir_pkg::POS_W'(rnd_x_reg) + $signed(nnir_pkg::POS_W'(cx));
        src_y    = nnir_pkg::POS_W'(rnd_y_reg) + $signed(nnir_pkg::POS_W'(cy));
        lim_x    = $signed(nnir_pkg::POS_W'(width_eff));
        lim_y    = $signed(nnir_pkg::POS_W'(height_eff));
        src_hit  = in_img_reg
                   && !src_x[nnir_pkg::POS_W-1] && (src_x < lim_x)
                   && !src_y[nnir_pkg::POS_W-1] && (src_y < lim_y);
        src_addr = {src_y[SB-1:0], src_x[SB-1:0]};
    end

endmodule

// File: rtl/core/nearest_neighbor_image_rotate.sv
// ----------------------------------------------------------------------------
// Nearest neighbor image rotation
// Rotates a stored ARGB frame about its center by inverse mapping.
// ----------------------------------------------------------------------------
// A write transaction stores one source pixel and gives no result. A fetch
// transaction goes from acceptance through load, multiply, sum, round,
// address and frame store read until its result enters the output register,
// all through one shared mapping datapath, so one fetch is in flight at a
// time. The next transaction is accepted as soon as the result sits in the
// output register, even while it still waits to be taken. The frame store is
// not cleared by reset; load every source pixel before it is fetched.
// Configuration must be written only while the core is idle; the core does not enforce it.
module nearest_neighbor_image_rotate (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [nnir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnir_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [nnir_pkg::SIDE_BITS-1:0]  s_pos_x,
    input  logic [nnir_pkg::SIDE_BITS-1:0]  s_pos_y,
    input  logic [nnir_pkg::PIXEL_W-1:0]    s_pixel_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nnir_pkg::PIXEL_W-1:0]    m_pixel_out,
    output logic                            m_inside_res
);

    `include "nearest_neighbor_image_rotate_defines.svh"

    nnir_pkg::state_t state_reg, state_next;

    logic signed [nnir_pkg::TRIG_W-1:0] cos_reg, sin_reg;
    logic [nnir_pkg::SIZE_W-1:0]        width_reg, height_reg;
    logic [nnir_pkg::SIZE_W-1:0]        width_eff, height_eff;

    nnir_pkg::map_ctl_t               map_ctl;
    logic [nnir_pkg::ADDR_W-1:0]      src_addr;
    logic                             src_hit;
    logic                             hit_reg;
    logic                             rd_en;
    logic [nnir_pkg::PIXEL_W-1:0]     rd_data;
    logic                             wr_en;
    logic                             fetch_acc;
    logic                             out_load;

    logic                             m_valid_reg, m_valid_next;
    logic [nnir_pkg::PIXEL_W-1:0]     pixel_out_reg;
    logic                             inside_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg    <= nnir_pkg::COS_RESET;
            sin_reg    <= nnir_pkg::SIN_RESET;
            width_reg  <= nnir_pkg::SIDE_RESET;
            height_reg <= nnir_pkg::SIDE_RESET;
        end else if (cfg_we) begin
            unique case (nnir_pkg::cfg_reg_t'(cfg_index))
                nnir_pkg::REG_COS:    cos_reg    <= cfg_wdata;
                nnir_pkg::REG_SIN:    sin_reg    <= cfg_wdata;
                nnir_pkg::REG_WIDTH:  width_reg  <= cfg_wdata[nnir_pkg::SIZE_W-1:0];
                nnir_pkg::REG_HEIGHT: height_reg <= cfg_wdata[nnir_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            width_eff = nnir_pkg::SIZE_W'(1);
        end else if (width_reg > nnir_pkg::SIDE_RESET) begin
            width_eff = nnir_pkg::SIDE_RESET;
        end else begin
            width_eff = width_reg;
        end
        if (height_reg == '0) begin
            height_eff = nnir_pkg::SIZE_W'(1);
        end else if (height_reg > nnir_pkg::SIDE_RESET) begin
            height_eff = nnir_pkg::SIDE_RESET;
        end else begin
            height_eff = height_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nnir_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        map_ctl    = '0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        wr_en      = 1'b0;
        fetch_acc  = 1'b0;
        unique case (state_reg)
            nnir_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                map_ctl.load = 1'b1;
                wr_en        = s_valid && (s_opcode == nnir_pkg::OP_WRITE);
                fetch_acc    = s_valid && (s_opcode == nnir_pkg::OP_FETCH);
                if (fetch_acc) begin
                    state_next = nnir_pkg::ST_MUL;
                end
            end
            nnir_pkg::ST_MUL: begin
                map_ctl.mul = 1'b1;
                state_next  = nnir_pkg::ST_SUM;
            end
            nnir_pkg::ST_SUM: begin
                map_ctl.sum = 1'b1;
                state_next  = nnir_pkg::ST_RND;
            end
            nnir_pkg::ST_RND: begin
                map_ctl.rnd = 1'b1;
                state_next  = nnir_pkg::ST_ADDR;
            end
            nnir_pkg::ST_ADDR: begin
                rd_en      = 1'b1;
                state_next = nnir_pkg::ST_DONE;
            end
            nnir_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = nnir_pkg::ST_IDLE;
                end
            end
            default: state_next = nnir_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            hit_reg <= src_hit;
        end
        if (out_load) begin
            pixel_out_reg  <= hit_reg ? rd_data : nnir_pkg::WHITE_PIXEL;
            inside_res_reg <= hit_reg;
        end
    end

    nnir_map u_map (
        .aclk       (aclk),
        .ctl        (map_ctl),
        .pos_x      (s_pos_x),
        .pos_y      (s_pos_y),
        .cos_q      (cos_reg),
        .sin_q      (sin_reg),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .src_addr   (src_addr),
        .src_hit    (src_hit)
    );

    nnir_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr ({s_pos_y, s_pos_x}),
        .wr_data (s_pixel_in),
        .rd_en   (rd_en),
        .rd_addr (src_addr),
        .rd_data (rd_data)
    );

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = pixel_out_reg;
    assign m_inside_res = inside_res_reg;

    `NNIR_ASSERT(a_fetch_starts, fetch_acc |=> (state_reg == nnir_pkg::ST_MUL))
    `NNIR_ASSERT(a_read_then_done, rd_en |=> (state_reg == nnir_pkg::ST_DONE))
    `NNIR_ASSERT(a_load_shows, out_load |=> m_valid)
    `NNIR_ASSERT(a_miss_is_white, (m_valid && !m_inside_res) |-> (m_pixel_out == nnir_pkg::WHITE_PIXEL))
    `NNIR_ASSERT_ALWAYS(a_no_store_clash, !(wr_en && rd_en))

endmodule

// File: tb/nearest_neighbor_image_rotate_tb.sv
// ----------------------------------------------------------------------------
// Nearest neighbor image rotation testbench
// Loads source pixels and fetches rotated pixels through the valid/ready
// channels. An in-bench model of the inverse mapping predicts every fetch,
// and each result is checked in order. The run covers a set of register
// settings, random idle cycles on both channels and one long output stall.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_rotate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nnir_pkg::*;

    typedef struct packed {
        op_t                  opcode;
        logic [SIDE_BITS-1:0] pos_x;
        logic [SIDE_BITS-1:0] pos_y;
        logic [PIXEL_W-1:0]   pixel;
    } pixel_cmd_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               in_image;
    } rotated_pixel_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_opcode     = 1'b0;
    logic [SIDE_BITS-1:0]  s_pos_x      = '0;
    logic [SIDE_BITS-1:0]  s_pos_y      = '0;
    logic [PIXEL_W-1:0]    s_pixel_in   = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [PIXEL_W-1:0]    m_pixel_out;
    logic                  m_inside_res;

    logic                  rx_hold      = 1'b0;
    int                    send_idle_pct = 32;
    int                    recv_idle_pct = 83;
    int                    accepted_cnt  = 0;
    int                    mismatch_cnt  = 0;
    int                    cmds_queued   = 0;

    logic signed [TRIG_W-1:0] cfg_cos    = COS_RESET;
    logic signed [TRIG_W-1:0] cfg_sin    = SIN_RESET;
    logic [SIZE_W-1:0]        cfg_width  = SIDE_RESET;
    logic [SIZE_W-1:0]        cfg_height = SIDE_RESET;

    logic [PIXEL_W-1:0] src_frame [MAX_SIDE*MAX_SIDE];
    bit                 frame_loaded [MAX_SIDE*MAX_SIDE];

    pixel_cmd_t     pixel_cmd_q[$];
    rotated_pixel_t rotated_pixel_q[$];
    pixel_cmd_t     cur_cmd;
    rotated_pixel_t got_pixel;

    nearest_neighbor_image_rotate i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_inside_res (m_inside_res)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int side_limit(logic [SIZE_W-1:0] side);
        if (side == 0) return 1;
        if (side > MAX_SIDE) return MAX_SIDE;
        return int'(side);
    endfunction

    // Divides by two to the fraction bits, rounding half away from zero.
    function automatic longint round_q(longint v);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + ROUND_HALF) >>> FRAC_BITS;
        return (v < 0) ? -r : r;
    endfunction

    // Maps an output pixel back into the source image; returns 1 when both the
    // output pixel and its source lie inside the image.
    function automatic bit map_source(input int px, input int py,
                                      output int sx, output int sy);
        int     w, h, cx, cy, dx, dy;
        longint c, s;
        w  = side_limit(cfg_width);
        h  = side_limit(cfg_height);
        sx = 0;
        sy = 0;
        if (px >= w || py >= h) return 1'b0;
        c  = longint'(cfg_cos);
        s  = longint'(cfg_sin);
        cx = w / 2;
        cy = h / 2;
        dx = px - cx;
        dy = py - cy;
        sx = int'(round_q(dx * c + dy * s)) + cx;
        sy = int'(round_q(-dx * s + dy * c)) + cy;
        return (sx >= 0 && sx < w && sy >= 0 && sy < h);
    endfunction

    function automatic void predict_rotation(pixel_cmd_t cmd);
        int sx, sy;
        if (cmd.opcode == OP_WRITE) begin
            src_frame[int'(cmd.pos_y) * MAX_SIDE + int'(cmd.pos_x)] = cmd.pixel;
        end else if (map_source(int'(cmd.pos_x), int'(cmd.pos_y), sx, sy)) begin
            rotated_pixel_q.push_back('{src_frame[sy * MAX_SIDE + sx], 1'b1});
        end else begin
            rotated_pixel_q.push_back('{WHITE_PIXEL, 1'b0});
        end
    endfunction

    function automatic void queue_write(int px, int py, logic [PIXEL_W-1:0] pixel);
        frame_loaded[py * MAX_SIDE + px] = 1'b1;
        pixel_cmd_q.push_back('{OP_WRITE, SIDE_BITS'(px), SIDE_BITS'(py), pixel});
        cmds_queued++;
    endfunction

    // A fetch whose source was never loaded gets that pixel loaded first.
    function automatic void queue_fetch(int px, int py);
        int sx, sy;
        if (map_source(px, py, sx, sy) && !frame_loaded[sy * MAX_SIDE + sx])
            queue_write(sx, sy, $urandom());
        pixel_cmd_q.push_back('{OP_FETCH, SIDE_BITS'(px), SIDE_BITS'(py), $urandom()});
        cmds_queued++;
    endfunction

    function automatic void note_mismatch(string what, rotated_pixel_t want,
                                          rotated_pixel_t got);
        if (mismatch_cnt < 10)
            $display("%0t: %s: expected pixel %08h inside %0b, got pixel %08h inside %0b",
                     $realtime, what, want.pixel, want.in_image, got.pixel, got.in_image);
        mismatch_cnt++;
    endfunction

    task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_COS:    cfg_cos    = value;
            REG_SIN:    cfg_sin    = value;
            REG_WIDTH:  cfg_width  = value[SIZE_W-1:0];
            REG_HEIGHT: cfg_height = value[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(logic [CFG_DATA_W-1:0] c, logic [CFG_DATA_W-1:0] s,
                                logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        set_reg(REG_COS, c);
        set_reg(REG_SIN, s);
        set_reg(REG_WIDTH, w);
        set_reg(REG_HEIGHT, h);
    endtask

    // Writes cause no result, so the task waits on after the queues have drained.
    task automatic wait_idle();
        while (pixel_cmd_q.size() != 0 || s_valid || rotated_pixel_q.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_rotation(cur_cmd);
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_cmd = pixel_cmd_q.pop_front();
                    s_valid    <= 1'b1;
                    s_opcode   <= cur_cmd.opcode;
                    s_pos_x    <= cur_cmd.pos_x;
                    s_pos_y    <= cur_cmd.pos_y;
                    s_pixel_in <= cur_cmd.pixel;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_pixel = '{m_pixel_out, m_inside_res};
                if (rotated_pixel_q.size() == 0) begin
                    note_mismatch("unexpected result", '0, got_pixel);
                end else if (got_pixel.pixel !== rotated_pixel_q[0].pixel ||
                             got_pixel.in_image !== rotated_pixel_q[0].in_image) begin
                    note_mismatch("result mismatch", rotated_pixel_q.pop_front(), got_pixel);
                end else begin
                    void'(rotated_pixel_q.pop_front());
                end
            end
            m_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // One long output stall while the input side keeps offering transactions.
    initial begin
        wait (aresetn === 1'b1);
        wait (accepted_cnt >= 100);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("nearest_neighbor_image_rotate verification failed");
        $finish;
    end

    initial begin
        int                    phase_start;
        int                    side_pick;
        real                   angle;
        logic [CFG_DATA_W-1:0] c, s, w, h;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings give the identity mapping over a full frame.
        queue_write(0, 0, 32'h0000_0000);
        queue_write(255, 255, 32'hFFFF_FFFF);
        queue_write(255, 0, 32'hA5A5_5A5A);
        queue_write(0, 255, 32'h5A5A_A5A5);
        queue_write(128, 128, 32'h8000_0001);
        queue_fetch(0, 0);
        queue_fetch(255, 255);
        queue_fetch(255, 0);
        queue_fetch(0, 255);
        queue_fetch(128, 128);
        wait_idle();

        // A half scale lands exactly on halves, in both directions.
        apply_config(16'sd8192, 16'sd0, 16'd256, 16'd256);
        queue_fetch(129, 128);
        queue_fetch(127, 128);
        wait_idle();

        // A quarter turn maps the corner outside the image.
        apply_config(16'sd0, 16'sd16384, 16'd256, 16'd256);
        queue_fetch(0, 0);
        queue_fetch(200, 10);
        wait_idle();

        // Sizes outside the legal range and trig values beyond one.
        apply_config(16'h8000, 16'h7FFF, 16'd0, 16'd511);
        queue_fetch(1, 0);
        queue_fetch(0, 5);
        queue_fetch(0, 255);
        wait_idle();

        apply_config(16'sd16384, 16'sd0, 16'd3, 16'd2);
        queue_fetch(2, 1);
        queue_fetch(3, 1);
        queue_fetch(0, 2);
        wait_idle();

        for (int phase = 0; phase < 9; phase++) begin
            send_idle_pct = (phase < 3) ? 32 : (phase < 6) ? 83 : 0;
            recv_idle_pct = (phase < 3) ? 83 : (phase < 6) ? 32 : 0;

            if ($urandom_range(0, 3) == 0) begin
                c = CFG_DATA_W'($urandom());
                s = CFG_DATA_W'($urandom());
            end else begin
                angle = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
                c = CFG_DATA_W'(int'($cos(angle) * 16384.0));
                s = CFG_DATA_W'(int'($sin(angle) * 16384.0));
            end
            side_pick = $urandom_range(0, 5);
            if (side_pick == 0) begin
                w = 16'd256;
                h = 16'd256;
            end else if (side_pick == 1) begin
                w = CFG_DATA_W'($urandom_range(0, 511));
                h = CFG_DATA_W'($urandom_range(0, 511));
            end else begin
                w = CFG_DATA_W'($urandom_range(1, 24));
                h = CFG_DATA_W'($urandom_range(1, 24));
            end
            apply_config(c, s, w, h);

            phase_start = cmds_queued;
            while (cmds_queued - phase_start < 200) begin
                if ($urandom_range(0, 99) < 30) begin
                    if ($urandom_range(0, 99) < 80)
                        queue_write($urandom_range(0, side_limit(cfg_width) - 1),
                                    $urandom_range(0, side_limit(cfg_height) - 1),
                                    $urandom());
                    else
                        queue_write($urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom());
                end else if ($urandom_range(0, 99) < 85) begin
                    queue_fetch($urandom_range(0, side_limit(cfg_width) - 1),
                                $urandom_range(0, side_limit(cfg_height) - 1));
                end else begin
                    queue_fetch($urandom_range(0, 255), $urandom_range(0, 255));
                end
            end
            wait_idle();
        end

        if (mismatch_cnt == 0 && rotated_pixel_q.size() == 0)
            $display("nearest_neighbor_image_rotate verification clean");
        else
            $display("nearest_neighbor_image_rotate verification failed");
        $finish;
    end

endmodule
